// File: design/swb64_pkg.sv
// Shared constants, types and a helper function of the subtract-with-borrow generator.
`default_nettype none

package swb64_pkg;

  localparam int LONG_LAG  = 13;
  localparam int SHORT_LAG = 7;
  localparam int WORD_W    = 64;
  localparam int LUX_W     = 7;
  localparam int IDX_W     = 4;
  localparam int PTR_W     = $clog2(LONG_LAG);

  localparam logic [PTR_W-1:0] LONG_PTR_RST  = PTR_W'(LONG_LAG - 1);
  localparam logic [PTR_W-1:0] SHORT_PTR_RST = PTR_W'(SHORT_LAG - 1);
  localparam logic [PTR_W:0]   BLOCK_END     = (PTR_W + 1)'(LONG_LAG);

  localparam logic [IDX_W-1:0] SEED_IDX_SET = IDX_W'(1);
  localparam logic [IDX_W-1:0] SEED_IDX_CLR = IDX_W'(2);

  typedef enum logic {
    CMD_SEED = 1'b0,
    CMD_NEXT = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [PTR_W-1:0]  idx;
    logic [WORD_W-1:0] value;
  } cmd_t;

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    if (p == '0) begin
      return LONG_PTR_RST;
    end
    return p - 1'b1;
  endfunction

endpackage

`default_nettype wire

// File: design/swb64_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module swb64_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 13
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// File: design/swb64_front.sv
// Front end: takes input words, classifies and fixes up seeds, queues commands, holds the luxury setting.
`default_nettype none

module swb64_front import swb64_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic              command_i,
  input  wire logic [IDX_W-1:0]  seed_index_i,
  input  wire logic [WORD_W-1:0] seed_value_i,
  input  wire logic              luxury_discard_we_i,
  input  wire logic [LUX_W-1:0]  luxury_discard_i,
  output logic      [LUX_W-1:0]  lux_o,
  output logic                   cmd_valid_o,
  output cmd_t                   cmd_o,
  input  wire logic              cmd_pop_i
);

  logic [LUX_W-1:0] lux_q;
  cmd_t             entry_q [2];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       cnt_q;
  logic             accept;
  logic             idx_ok;
  logic             keep;
  cmd_t             new_cmd;

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_q];
  assign lux_o       = lux_q;

  assign accept = push_i & ~full_o;
  assign idx_ok = (32'(seed_index_i) < 32'(LONG_LAG));
  assign keep   = accept & ((cmd_e'(command_i) == CMD_NEXT) | idx_ok);

  always_comb begin
    new_cmd.cmd   = cmd_e'(command_i);
    new_cmd.idx   = PTR_W'(seed_index_i);
    new_cmd.value = seed_value_i;
    if (seed_index_i == SEED_IDX_SET) begin
      new_cmd.value[0] = 1'b1;
    end else if (seed_index_i == SEED_IDX_CLR) begin
      new_cmd.value[0] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      entry_q[wr_q] <= new_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lux_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (luxury_discard_we_i) begin
        lux_q <= luxury_discard_i;
      end
      if (keep) begin
        wr_q <= ~wr_q;
      end
      if (cmd_pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(keep) - 2'(cmd_pop_i);
    end
  end

endmodule

`default_nettype wire

// File: design/swb64_back.sv
// Back end: lag store, subtract-with-borrow draws, luxury bursts and result queue.
`default_nettype none

module swb64_back import swb64_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [LUX_W-1:0]  lux_i,
  input  wire logic              cmd_valid_i,
  input  cmd_t                   cmd_i,
  output logic                   cmd_pop_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output logic      [WORD_W-1:0] random_word_o
);

  logic              borrow_q, borrow_d;
  logic [PTR_W-1:0]  lptr_q, lptr_d;
  logic [PTR_W-1:0]  sptr_q, sptr_d;
  logic [PTR_W-1:0]  bpos_q, bpos_d;
  logic [LUX_W-1:0]  rem_q, rem_d;
  logic              burst_q, burst_d;
  logic              fresh_q, fresh_d;

  logic              we;
  logic [PTR_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rd_l;
  logic [WORD_W-1:0] rd_s;
  logic [WORD_W-1:0] t;
  logic              draw;
  logic              opush;
  logic              opop;
  logic              out_room;

  logic [WORD_W-1:0] oword_q [2];
  logic              owr_q;
  logic              ord_q;
  logic [1:0]        ocnt_q;

  swb64_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LONG_LAG)
  ) u_lag_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (lptr_d),
    .rdata_a_o (rd_l),
    .raddr_b_i (sptr_d),
    .rdata_b_o (rd_s)
  );

  assign t        = rd_s - rd_l - WORD_W'(borrow_q);
  assign out_room = (ocnt_q != 2'd2);

  always_comb begin
    logic [PTR_W:0]   bpos_inc;
    logic [LUX_W-1:0] rem;
    bpos_inc  = '0;
    rem       = '0;
    borrow_d  = borrow_q;
    lptr_d    = lptr_q;
    sptr_d    = sptr_q;
    bpos_d    = bpos_q;
    rem_d     = rem_q;
    burst_d   = burst_q;
    fresh_d   = fresh_q;
    we        = 1'b0;
    waddr     = lptr_q;
    wdata     = t;
    draw      = 1'b0;
    opush     = 1'b0;
    cmd_pop_o = 1'b0;
    if (!fresh_q) begin
      // refetch the taps after reset or a seed write
      fresh_d = 1'b1;
    end else if (cmd_valid_i) begin
      unique case (cmd_i.cmd)
        CMD_SEED: begin
          we        = 1'b1;
          waddr     = cmd_i.idx;
          wdata     = cmd_i.value;
          borrow_d  = 1'b1;
          lptr_d    = LONG_PTR_RST;
          sptr_d    = SHORT_PTR_RST;
          bpos_d    = '0;
          burst_d   = 1'b0;
          fresh_d   = 1'b0;
          cmd_pop_o = 1'b1;
        end
        CMD_NEXT: begin
          if (out_room) begin
            if (!burst_q) begin
              bpos_inc = {1'b0, bpos_q} + 1'b1;
              if (bpos_inc == BLOCK_END) begin
                bpos_d = '0;
                rem    = lux_i;
              end else begin
                bpos_d = bpos_inc[PTR_W-1:0];
              end
            end else begin
              rem = rem_q;
            end
            draw = 1'b1;
            if (rem != '0) begin
              burst_d = 1'b1;
              rem_d   = rem - 1'b1;
            end else begin
              burst_d   = 1'b0;
              opush     = 1'b1;
              cmd_pop_o = 1'b1;
            end
          end
        end
      endcase
    end
    if (draw) begin
      we       = 1'b1;
      waddr    = lptr_q;
      wdata    = t;
      borrow_d = (rd_s < t);
      lptr_d   = ptr_dec(lptr_q);
      sptr_d   = ptr_dec(sptr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      borrow_q <= 1'b1;
      lptr_q   <= LONG_PTR_RST;
      sptr_q   <= SHORT_PTR_RST;
      bpos_q   <= '0;
      rem_q    <= '0;
      burst_q  <= 1'b0;
      fresh_q  <= 1'b0;
    end else begin
      borrow_q <= borrow_d;
      lptr_q   <= lptr_d;
      sptr_q   <= sptr_d;
      bpos_q   <= bpos_d;
      rem_q    <= rem_d;
      burst_q  <= burst_d;
      fresh_q  <= fresh_d;
    end
  end

  assign opop          = pop_i & ~empty_o;
  assign empty_o       = (ocnt_q == 2'd0);
  assign random_word_o = oword_q[ord_q];

  always_ff @(posedge clk_i) begin
    if (opush) begin
      oword_q[owr_q] <= t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (opush) begin
        owr_q <= ~owr_q;
      end
      if (opop) begin
        ord_q <= ~ord_q;
      end
      ocnt_q <= ocnt_q + 2'(opush) - 2'(opop);
    end
  end

endmodule

`default_nettype wire

// File: design/swb64_prng_with_luxury.sv
// Top level of the 64-bit subtract-with-borrow generator with luxury decimation.
// A next word reaches the result ports through the command queue and then the result queue;
// it can wait on a luxury burst, a full result queue or a tap refetch after a seed write.
// Throughput: one word per cycle while nothing holds it; every 13th next word first discards
// luxury_discard draws. Seed writes make the taps refetch from the registered lag RAM.
// Reset clears the queues, borrow to 1, pointers to 12 and 6, block position and luxury to 0.
`default_nettype none

module swb64_prng_with_luxury import swb64_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic              command_i,
  input  wire logic [IDX_W-1:0]  seed_index_i,
  input  wire logic [WORD_W-1:0] seed_value_i,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output logic      [WORD_W-1:0] random_word_o,
  input  wire logic              luxury_discard_we_i,
  input  wire logic [LUX_W-1:0]  luxury_discard_i
);

  logic [LUX_W-1:0] lux;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;

  swb64_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push_i              (push_i),
    .full_o              (full_o),
    .command_i           (command_i),
    .seed_index_i        (seed_index_i),
    .seed_value_i        (seed_value_i),
    .luxury_discard_we_i (luxury_discard_we_i),
    .luxury_discard_i    (luxury_discard_i),
    .lux_o               (lux),
    .cmd_valid_o         (cmd_valid),
    .cmd_o               (cmd),
    .cmd_pop_i           (cmd_pop)
  );

  swb64_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lux_i         (lux),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .random_word_o (random_word_o)
  );

endmodule

`default_nettype wire

// File: design/swb64_checker.sv
// Port-level checks of the generator, bound to the top level.
`default_nettype none

module swb64_checker import swb64_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              push_i,
  input wire logic              full_o,
  input wire logic              empty_o,
  input wire logic              pop_i,
  input wire logic [WORD_W-1:0] random_word_o
);

  a_reset_clear: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty_o && !full_o)
    else $error("queues not clear after reset");

  a_word_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(random_word_o))
    else $error("waiting word lost or changed");

  a_no_fill_without_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full_o && !push_i |=> !full_o)
    else $error("command queue filled without a push");

endmodule

bind swb64_prng_with_luxury swb64_checker u_chk (.*);

`default_nettype wire
